[design/bol_pkg.sv]
// Shared types and constants for the bounded ordered list.
// Transaction payload structs, operation and status codes, cell command.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bol_pkg;

    localparam int OP_W    = 3;
    localparam int POS_W   = 4;
    localparam int VALUE_W = 64;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT   = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK    = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT    = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK     = 3'd3;
    localparam logic [OP_W-1:0] OP_INSERT_AFTER = 3'd4;
    localparam logic [OP_W-1:0] OP_ERASE        = 3'd5;
    localparam logic [OP_W-1:0] OP_READ         = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } bol_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] count;
    } bol_out_t;

    // Broadcast to every cell: open a gap or close one at the given index
    typedef struct packed {
        logic ins;
        logic del;
    } cell_cmd_t;

endpackage

`default_nettype wire

[design/bounded_ordered_list_top.sv]
// Top level of the bounded ordered list: operation decode, entry count,
// row of bol_cell instances and the result register. Depends on bol_pkg, bol_cell.
// Result registered; valid in the cycle after the input transaction is accepted.
// One transaction per cycle while results are taken; every cell shifts or loads
// in parallel in the accepting cycle; the result register frees as soon as taken.
// Reset (aresetn low, synchronous): list empty, no result pending. Cell
// contents are not cleared; entries beyond the count are never read.
`timescale 1ns / 1ps
`default_nettype none

module bounded_ordered_list_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire bol_pkg::bol_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bol_pkg::bol_out_t      m_data
);
    import bol_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               m_valid_reg;
    bol_out_t           m_data_reg;
    bol_out_t           result;
    logic               accept;
    logic               full;
    logic               empty;
    logic               in_list;
    logic [CMP_W-1:0]   pos_ext;
    logic [IDX_W-1:0]   rd_idx;
    logic [CNT_W-1:0]   at;
    cell_cmd_t          cmd;
    cell_cmd_t          cmd_q;
    logic [VALUE_W-1:0] cell_data [MAX_ENTRIES];

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign full    = (cnt_reg == MAX_CNT);
    assign empty   = (cnt_reg == '0);
    assign pos_ext = CMP_W'(s_data.position);
    assign in_list = pos_ext < CMP_W'(cnt_reg);
    assign rd_idx  = IDX_W'(s_data.position);

    always_comb begin
        cmd               = '{ins: 1'b0, del: 1'b0};
        at                = '0;
        cnt_next          = cnt_reg;
        result.status     = ST_OK;
        result.read_value = '0;
        case (s_data.op)
            OP_PUSH_FRONT: begin
                if (full) begin
                    result.status = ST_FULL;
                end else begin
                    cmd.ins  = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    result.status = ST_FULL;
                end else begin
                    cmd.ins  = 1'b1;
                    at       = cnt_reg;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    result.status = ST_EMPTY;
                end else begin
                    cmd.del  = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    result.status = ST_EMPTY;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            OP_INSERT_AFTER: begin
                if (full) begin
                    result.status = ST_FULL;
                end else if (!in_list) begin
                    result.status = ST_BAD_INDEX;
                end else begin
                    cmd.ins  = 1'b1;
                    // pos < count < MAX here, so pos + 1 fits the count width
                    at       = CNT_W'(pos_ext + 1'b1);
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_ERASE: begin
                if (!in_list) begin
                    result.status = ST_BAD_INDEX;
                end else begin
                    cmd.del  = 1'b1;
                    at       = CNT_W'(pos_ext);
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            OP_READ: begin
                if (!in_list) begin
                    result.status = ST_BAD_INDEX;
                end else begin
                    result.read_value = cell_data[rd_idx];
                end
            end
            default: begin
            end
        endcase
        result.count = COUNT_W'(cnt_next);
    end

    assign cmd_q.ins = cmd.ins && accept;
    assign cmd_q.del = cmd.del && accept;

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        logic [VALUE_W-1:0] left_d;
        logic [VALUE_W-1:0] right_d;
        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == MAX_ENTRIES - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end
        bol_cell #(
            .IDX  (i),
            .AT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd_q),
            .at         (at),
            .value      (s_data.value),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                cnt_reg <= cnt_next;
            end
            if (s_ready) begin
                m_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= MAX_CNT)
        else $error("entry count above capacity");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !full && (s_data.op == OP_PUSH_FRONT || s_data.op == OP_PUSH_BACK)
        |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("push did not grow the list");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_FULL |-> m_data.count == COUNT_W'(MAX_ENTRIES))
        else $error("full reported with room left");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_EMPTY |-> m_data.count == '0)
        else $error("empty reported on non-empty list");

    a_rd_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.read_value != '0 |-> m_data.status == ST_OK)
        else $error("read value on failed transaction");
`endif

endmodule

`default_nettype wire

[design/bol_cell.sv]
// One storage cell of the list row; holds one entry and trades with its neighbors.
// Depends on bol_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bol_cell #(
    parameter int IDX  = 0,
    parameter int AT_W = 5
) (
    input  wire logic                            aclk,
    input  wire bol_pkg::cell_cmd_t              cmd,
    input  wire logic [AT_W-1:0]                 at,
    input  wire logic [bol_pkg::VALUE_W-1:0]     value,
    input  wire logic [bol_pkg::VALUE_W-1:0]     left_data,
    input  wire logic [bol_pkg::VALUE_W-1:0]     right_data,
    output logic [bol_pkg::VALUE_W-1:0]          data
);
    import bol_pkg::*;

    localparam logic [AT_W-1:0] MY_IDX = AT_W'(IDX);

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (cmd.ins) begin
            if (MY_IDX == at) begin
                data_next = value;
            end else if (MY_IDX > at) begin
                data_next = left_data;
            end
        end else if (cmd.del && MY_IDX >= at) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking bench for bounded_ordered_list_top: a directed table, then three
// random phases under varied stalls. Depends on bol_pkg and the design top.
// Expected results: a table row's own, else a shadow queue of the list contents.
`timescale 1ns / 1ps

module tb_top;
    import bol_pkg::*;

    localparam int LIST_DEPTH  = 16;
    localparam int HOLD_CYCLES = 40;
    localparam int RAND_PHASE  = 250;
    localparam int DRAIN_LIMIT = 2000;

    // op 7 has no package name; the block treats it as a no-op
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
        logic               has_want;
        bol_out_t           want;
    } op_row_t;

    localparam logic [VALUE_W-1:0] ONES = {VALUE_W{1'b1}};
    localparam logic [VALUE_W-1:0] MSB  = {1'b1, {(VALUE_W-1){1'b0}}};

    localparam int N_ROWS = 25;
    localparam op_row_t OP_TABLE [N_ROWS] = '{
        '{OP_POP_FRONT,    4'd0,  64'd0, 1'b1, '{ST_EMPTY,     64'd0, 5'd0}},
        '{OP_POP_BACK,     4'd0,  64'd0, 1'b1, '{ST_EMPTY,     64'd0, 5'd0}},
        '{OP_READ,         4'd0,  64'd0, 1'b1, '{ST_BAD_INDEX, 64'd0, 5'd0}},
        '{OP_INSERT_AFTER, 4'd0,  64'd5, 1'b1, '{ST_BAD_INDEX, 64'd0, 5'd0}},
        '{OP_ERASE,        4'd15, 64'd0, 1'b1, '{ST_BAD_INDEX, 64'd0, 5'd0}},
        '{OP_UNUSED,       4'd15, ONES,  1'b1, '{ST_OK,        64'd0, 5'd0}},
        '{OP_PUSH_BACK,    4'd0,  ONES,  1'b1, '{ST_OK,        64'd0, 5'd1}},
        '{OP_PUSH_FRONT,   4'd0,  64'd0, 1'b1, '{ST_OK,        64'd0, 5'd2}},
        '{OP_READ,         4'd1,  64'd0, 1'b1, '{ST_OK,        ONES,  5'd2}},
        '{OP_READ,         4'd0,  ONES,  1'b1, '{ST_OK,        64'd0, 5'd2}},
        // insert after the last entry appends
        '{OP_INSERT_AFTER, 4'd1,  MSB,   1'b1, '{ST_OK,        64'd0, 5'd3}},
        '{OP_READ,         4'd2,  64'd0, 1'b1, '{ST_OK,        MSB,   5'd3}},
        '{OP_INSERT_AFTER, 4'd0,  64'h0123_4567_89ab_cdef, 1'b0, '0},
        '{OP_READ,         4'd15, 64'd0, 1'b1, '{ST_BAD_INDEX, 64'd0, 5'd4}},
        '{OP_READ,         4'd1,  64'd0, 1'b0, '0},
        '{OP_ERASE,        4'd3,  64'd0, 1'b0, '0},
        '{OP_ERASE,        4'd15, 64'd0, 1'b1, '{ST_BAD_INDEX, 64'd0, 5'd3}},
        '{OP_POP_FRONT,    4'd0,  64'd0, 1'b0, '0},
        '{OP_POP_BACK,     4'd0,  64'd0, 1'b0, '0},
        '{OP_READ,         4'd0,  64'd0, 1'b0, '0},
        '{OP_PUSH_FRONT,   4'd0,  64'h5555_5555_5555_5555, 1'b0, '0},
        '{OP_ERASE,        4'd0,  64'd0, 1'b0, '0},
        // popping the last entry must bring the count to zero
        '{OP_POP_BACK,     4'd0,  64'd0, 1'b1, '{ST_OK,        64'd0, 5'd0}},
        '{OP_POP_FRONT,    4'd0,  64'd0, 1'b1, '{ST_EMPTY,     64'd0, 5'd0}},
        '{OP_READ,         4'd0,  64'd0, 1'b1, '{ST_BAD_INDEX, 64'd0, 5'd0}}
    };

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    bol_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    bol_out_t m_data;

    logic [VALUE_W-1:0] shadow_list [$];
    bol_out_t           results_due_q [$];

    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  hold_req    = 1'b0;
    bit  filling     = 1'b1;
    int  fail_count  = 0;
    int  ops_sent    = 0;
    int  results_checked = 0;
    int  n_full = 0;
    int  n_empty = 0;
    int  n_bad = 0;
    int  max_len_seen = 0;

    bounded_ordered_list_top #(
        .MAX_ENTRIES(LIST_DEPTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Apply one operation to the shadow list and return the status, read value and count it yields
    function automatic bol_out_t apply_list_op(bol_in_t item);
        bol_out_t res;
        int       len;
        int       pos;
        bit       full;
        bit       in_range;
        len      = shadow_list.size();
        pos      = int'(item.position);
        full     = (len >= LIST_DEPTH);
        in_range = (pos < len);
        res      = '0;
        res.status = ST_OK;
        case (item.op)
            OP_PUSH_FRONT: begin
                if (full) res.status = ST_FULL;
                else shadow_list.insert(0, item.value);
            end
            OP_PUSH_BACK: begin
                if (full) res.status = ST_FULL;
                else shadow_list.insert(len, item.value);
            end
            OP_POP_FRONT: begin
                if (len == 0) res.status = ST_EMPTY;
                else shadow_list.delete(0);
            end
            OP_POP_BACK: begin
                if (len == 0) res.status = ST_EMPTY;
                else shadow_list.delete(len - 1);
            end
            OP_INSERT_AFTER: begin
                if (full) res.status = ST_FULL;
                else if (!in_range) res.status = ST_BAD_INDEX;
                else shadow_list.insert(pos + 1, item.value);
            end
            OP_ERASE: begin
                if (!in_range) res.status = ST_BAD_INDEX;
                else shadow_list.delete(pos);
            end
            OP_READ: begin
                if (!in_range) res.status = ST_BAD_INDEX;
                else res.read_value = shadow_list[pos];
            end
            default: ;
        endcase
        res.count = COUNT_W'(shadow_list.size());
        return res;
    endfunction

    // Random operation biased by a fill/drain trend so the list swings
    // between empty and full
    function automatic bol_in_t pick_operation();
        bol_in_t item;
        int      len;
        int      r;
        len = shadow_list.size();
        if (len == LIST_DEPTH && $urandom_range(3) == 0) filling = 1'b0;
        else if (len == 0 && $urandom_range(3) == 0) filling = 1'b1;
        else if ($urandom_range(49) == 0) filling = ~filling;

        item.value = {$urandom, $urandom};
        case ($urandom_range(15))
            0: item.value = '0;
            1: item.value = ONES;
            default: ;
        endcase

        r = $urandom_range(99);
        if (r < 5) begin
            item.op = OP_W'($urandom_range(7));
        end else if (r < 30) begin
            item.op = OP_READ;
        end else if (filling) begin
            case ($urandom_range(9))
                0, 1, 2: item.op = OP_PUSH_FRONT;
                3, 4, 5: item.op = OP_PUSH_BACK;
                6, 7:    item.op = OP_INSERT_AFTER;
                8:       item.op = OP_ERASE;
                default: item.op = OP_POP_BACK;
            endcase
        end else begin
            case ($urandom_range(9))
                0, 1, 2: item.op = OP_POP_FRONT;
                3, 4, 5: item.op = OP_POP_BACK;
                6, 7:    item.op = OP_ERASE;
                8:       item.op = OP_PUSH_BACK;
                default: item.op = OP_INSERT_AFTER;
            endcase
        end

        if (len > 0 && $urandom_range(4) != 0)
            item.position = POS_W'($urandom_range(len - 1));
        else
            item.position = POS_W'($urandom_range(15));
        return item;
    endfunction

    // Offer one transaction, hold it until taken, then log what must come back
    task automatic send_op(input bol_in_t item, input logic has_want, input bol_out_t want);
        bol_out_t predicted;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_list_op(item);
        results_due_q.insert(results_due_q.size(), has_want ? want : predicted);
        ops_sent++;
        if (shadow_list.size() > max_len_seen) max_len_seen = shadow_list.size();
    endtask

    task automatic run_random(input int n_ops);
        for (int i = 0; i < n_ops; i++)
            send_op(pick_operation(), 1'b0, '0);
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        while (results_due_q.size() != 0) @(posedge aclk);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        bol_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (results_due_q.size() == 0) begin
                $error("unexpected result transaction: status %0d count %0d",
                       m_data.status, m_data.count);
                fail_count++;
            end else begin
                want = results_due_q[0];
                results_due_q.delete(0);
                results_checked++;
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    fail_count++;
                end
                if (m_data.read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h",
                           want.read_value, m_data.read_value);
                    fail_count++;
                end
                if (m_data.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, m_data.count);
                    fail_count++;
                end
                case (want.status)
                    ST_FULL:      n_full++;
                    ST_EMPTY:     n_empty++;
                    ST_BAD_INDEX: n_bad++;
                    default: ;
                endcase
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", results_due_q.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_ROWS; i++)
            send_op(bol_in_t'{OP_TABLE[i].op, OP_TABLE[i].position, OP_TABLE[i].value},
                    OP_TABLE[i].has_want, OP_TABLE[i].want);

        tx_idle_pct = 30;
        rx_idle_pct = 57;
        run_random(RAND_PHASE);
        pause_until_drained();

        tx_idle_pct = 57;
        rx_idle_pct = 30;
        run_random(RAND_PHASE);

        // back-to-back traffic; a long result stall first backs up the input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        run_random(RAND_PHASE);
        s_valid <= 1'b0;

        for (int i = 0; i < DRAIN_LIMIT && results_due_q.size() != 0; i++)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (results_due_q.size() != 0) begin
            $error("%0d expected results never arrived", results_due_q.size());
            fail_count++;
        end

        $display("Ran %0d list operations, %0d results checked, longest list %0d",
                 ops_sent, results_checked, max_len_seen);
        $display("Rejections seen: full %0d, empty %0d, bad index %0d",
                 n_full, n_empty, n_bad);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
design/bol_pkg.sv
design/bol_cell.sv
design/bounded_ordered_list_top.sv
tb/sv/tb_top.sv
